FILE: src/cthash_pkg.sv
// shared types, constants and crc functions for the command token id hash
package cthash_pkg;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] NUL_BYTE   = 8'h00;
  localparam logic [7:0] FWD_POLY   = 8'h31;
  localparam logic [7:0] REF_POLY   = 8'h8C;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       line_end;
  } cthash_in_t;

  typedef struct packed {
    logic [31:0] command_id;
    logic        token_present;
  } cthash_out_t;

  // crc-8 poly 0x31, msb first, one byte
  function automatic logic [7:0] crc8_fwd(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ FWD_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // reflected crc-8 poly 0x8c, lsb first, one byte
  function automatic logic [7:0] crc8_ref(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = {1'b0, c[7:1]} ^ REF_POLY;
      end else begin
        c = {1'b0, c[7:1]};
      end
    end
    return c;
  endfunction

endpackage

FILE: src/cthash_in_reg.sv
// input register stage with stall back to the source
module cthash_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  cthash_pkg::cthash_in_t in_data,
  output logic                 in_stall,
  input  logic                 advance,
  output logic                 s1_valid,
  output cthash_pkg::cthash_in_t s1_data
);

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  cthash_pkg::cthash_in_t s1_data_r;
  logic                   load;

  assign load         = !s1_valid_r || advance;
  assign s1_valid_nxt = load ? in_valid : s1_valid_r;
  assign in_stall     = s1_valid_r && !advance;
  assign s1_valid     = s1_valid_r;
  assign s1_data      = s1_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      s1_data_r <= in_data;
    end
  end

endmodule

FILE: src/cthash_token_acc.sv
// token scanner and hash accumulator, one byte per step
module cthash_token_acc (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  cthash_pkg::cthash_in_t s1_data,
  output cthash_pkg::cthash_out_t result
);

  logic       started_r, started_nxt;
  logic       closed_r, closed_nxt;
  logic [5:0] first_r, first_nxt;
  logic [4:0] len_r, len_nxt;
  logic [4:0] sum_r, sum_nxt;
  logic [7:0] fcrc_r, fcrc_nxt;
  logic [7:0] rcrc_r, rcrc_nxt;
  logic       absorb;
  logic [7:0] b;

  assign b = s1_data.char_byte;

  always_comb begin
    started_nxt = started_r;
    closed_nxt  = closed_r;
    first_nxt   = first_r;
    absorb      = 1'b0;
    if (!closed_r) begin
      if (!started_r) begin
        if (b == cthash_pkg::NUL_BYTE) begin
          closed_nxt = 1'b1;
        end else if (b != cthash_pkg::SPACE_BYTE) begin
          started_nxt = 1'b1;
          first_nxt   = b[5:0];
          absorb      = 1'b1;
        end
      end else if (b == cthash_pkg::NUL_BYTE || b == cthash_pkg::SPACE_BYTE) begin
        closed_nxt = 1'b1;
      end else begin
        absorb = 1'b1;
      end
    end
  end

  assign len_nxt  = absorb ? len_r + 5'd1 : len_r;
  assign sum_nxt  = absorb ? sum_r + b[4:0] : sum_r;
  assign fcrc_nxt = absorb ? cthash_pkg::crc8_fwd(fcrc_r, b) : fcrc_r;
  assign rcrc_nxt = absorb ? cthash_pkg::crc8_ref(rcrc_r, b) : rcrc_r;

  assign result = {(started_nxt ? {first_nxt, len_nxt, sum_nxt, fcrc_nxt, rcrc_nxt} : 32'd0),
                   started_nxt};

  // line end emits and returns the scanner to its reset state
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && s1_data.line_end)) begin
      started_r <= 1'b0;
      closed_r  <= 1'b0;
      first_r   <= '0;
      len_r     <= '0;
      sum_r     <= '0;
      fcrc_r    <= '0;
      rcrc_r    <= '0;
    end else if (step_en) begin
      started_r <= started_nxt;
      closed_r  <= closed_nxt;
      first_r   <= first_nxt;
      len_r     <= len_nxt;
      sum_r     <= sum_nxt;
      fcrc_r    <= fcrc_nxt;
      rcrc_r    <= rcrc_nxt;
    end
  end

endmodule

FILE: src/command_token_id_hash_unit.sv
// Command token hash unit: takes one command-line byte per transaction and, on the byte
// marked line_end, returns one transaction holding the 32-bit ID of the first token
// (first char bits, length, byte sum, forward and reflected crc-8) and a token_present
// flag. A byte passes through an input register, then the scanner and both crc-8 byte
// updates, then the result register. One byte is accepted every cycle as long as the
// result register is drained. Only a line_end byte waits when a previous result is
// still stalled at the output.
module command_token_id_hash_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  cthash_pkg::cthash_in_t  in_data,
  output logic                    in_stall,
  output logic                    out_valid,
  output cthash_pkg::cthash_out_t out_data,
  input  logic                    out_stall
);

  logic                    s1_valid;
  cthash_pkg::cthash_in_t  s1_data;
  logic                    advance;
  logic                    emit;
  cthash_pkg::cthash_out_t result;
  logic                    out_valid_r, out_valid_nxt;
  cthash_pkg::cthash_out_t out_data_r;

  // a byte that emits nothing never waits on the output
  assign advance = s1_valid && (!s1_data.line_end || !out_valid_r || !out_stall);
  assign emit    = advance && s1_data.line_end;

  cthash_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  cthash_token_acc u_token_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .s1_data (s1_data),
    .result  (result)
  );

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input only stalls behind a held result
  a_stall_needs_held_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_valid && s1_data.line_end))
    else $error("input stalled without a held result");

  // a new result only follows a line_end byte
  a_rise_from_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit))
    else $error("result raised without a line_end byte");

  // no token means an all-zero id
  a_empty_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.token_present) |-> (out_data_r.command_id == 32'd0))
    else $error("nonzero id without a token");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit)
    else $error("result overwritten while stalled");

endmodule
